/* design/xbg_pkg.sv */
// xbg_pkg: shared types, constants and the microcode program of the bounded xoshiro generator
// no dependencies; used by xbg_dp, xbg_seq and the top level
`timescale 1ns / 1ps

package xbg_pkg;

	// splitmix64 and xoshiro256** constants
	localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
	localparam int unsigned SHIFT_T    = 17;
	localparam int unsigned ROT_S3     = 45;

	localparam int unsigned StepW = 6;
	typedef logic [StepW-1:0] step_t;

	// entry points of the microcode program
	localparam step_t ST_IDLE      = 6'd0;
	localparam step_t ST_EXPAND    = 6'd1;
	localparam step_t ST_RAW       = 6'd12;
	localparam step_t ST_BND       = 6'd14;
	localparam step_t ST_CHECK     = 6'd24;
	localparam step_t ST_EMIT_HI   = 6'd31;
	localparam step_t ST_EMIT_ZERO = 6'd32;

	// datapath operation of one step
	typedef enum logic [2:0] {
		OP_NOP,
		OP_SM_INIT,
		OP_XS27,
		OP_WORD,
		OP_DRAW,
		OP_EMIT,
		OP_DIV_START
	} op_t;

	// second multiplier operand
	typedef enum logic [1:0] {
		BS_MIX_A,
		BS_MIX_B,
		BS_BOUND
	} bsel_t;

	// which 32-bit halves go into the multiplier
	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL,
		MS_HH
	} msel_t;

	// product accumulator action
	typedef enum logic [1:0] {
		AC_HOLD,
		AC_LOAD,
		AC_ADD32,
		AC_ADD64
	} acc_t;

	// result source on emit
	typedef enum logic [1:0] {
		SRC_Z,
		SRC_HI,
		SRC_ZERO
	} src_t;

	// next step selection
	typedef enum logic [3:0] {
		J_NEXT,
		J_ALWAYS,
		J_DISPATCH,
		J_CNT,
		J_ZERO,
		J_LO_GE_N,
		J_LO_GE_LIM,
		J_WAIT_DIV,
		J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		op_t   op;
		bsel_t b_sel;
		msel_t m_sel;
		acc_t  acc;
		src_t  src;
		jmp_t  jmp;
		step_t target;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		uword_t uw;
		logic   in_acc;
		logic   seed_acc;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic bound_zero;
		logic lo_ge_n;
		logic lo_ge_lim;
		logic div_busy;
		logic out_free;
		logic cnt_last;
	} stat_t;

	function automatic uword_t mk(op_t op, bsel_t b, msel_t m, acc_t a, src_t s, jmp_t j,
			step_t t);
		uword_t w;
		w.op     = op;
		w.b_sel  = b;
		w.m_sel  = m;
		w.acc    = a;
		w.src    = s;
		w.jmp    = j;
		w.target = t;
		return w;
	endfunction

	// microcode program
	function automatic uword_t ucode_rom(step_t pc);
		uword_t w;
		case (pc)
			// wait for a beat or a seed write
			6'd0:  w = mk(OP_NOP, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_DISPATCH, ST_IDLE);
			// splitmix64: one state word per pass
			6'd1:  w = mk(OP_SM_INIT, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd2:  w = mk(OP_NOP, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd3:  w = mk(OP_NOP, BS_MIX_A, MS_LH, AC_LOAD, SRC_Z, J_NEXT, ST_IDLE);
			6'd4:  w = mk(OP_NOP, BS_MIX_A, MS_HL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd5:  w = mk(OP_NOP, BS_MIX_A, MS_LL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd6:  w = mk(OP_XS27, BS_MIX_B, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd7:  w = mk(OP_NOP, BS_MIX_B, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd8:  w = mk(OP_NOP, BS_MIX_B, MS_LH, AC_LOAD, SRC_Z, J_NEXT, ST_IDLE);
			6'd9:  w = mk(OP_NOP, BS_MIX_B, MS_HL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd10: w = mk(OP_NOP, BS_MIX_B, MS_LL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd11: w = mk(OP_WORD, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_CNT, ST_EXPAND);
			// raw draw
			6'd12: w = mk(OP_DRAW, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd13: w = mk(OP_EMIT, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_WAIT_OUT, ST_IDLE);
			// bounded draw, first product
			6'd14: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_ZERO, ST_EMIT_ZERO);
			6'd15: w = mk(OP_DRAW, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd16: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd17: w = mk(OP_NOP, BS_BOUND, MS_LH, AC_LOAD, SRC_Z, J_NEXT, ST_IDLE);
			6'd18: w = mk(OP_NOP, BS_BOUND, MS_HL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd19: w = mk(OP_NOP, BS_BOUND, MS_HH, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd20: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_ADD64, SRC_Z, J_NEXT, ST_IDLE);
			6'd21: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_LO_GE_N, ST_EMIT_HI);
			// rejection threshold
			6'd22: w = mk(OP_DIV_START, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd23: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_WAIT_DIV, ST_IDLE);
			// rejection loop
			6'd24: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_LO_GE_LIM, ST_EMIT_HI);
			6'd25: w = mk(OP_DRAW, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd26: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_HOLD, SRC_Z, J_NEXT, ST_IDLE);
			6'd27: w = mk(OP_NOP, BS_BOUND, MS_LH, AC_LOAD, SRC_Z, J_NEXT, ST_IDLE);
			6'd28: w = mk(OP_NOP, BS_BOUND, MS_HL, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd29: w = mk(OP_NOP, BS_BOUND, MS_HH, AC_ADD32, SRC_Z, J_NEXT, ST_IDLE);
			6'd30: w = mk(OP_NOP, BS_BOUND, MS_LL, AC_ADD64, SRC_Z, J_ALWAYS, ST_CHECK);
			// result beats
			6'd31: w = mk(OP_EMIT, BS_BOUND, MS_LL, AC_HOLD, SRC_HI, J_WAIT_OUT, ST_IDLE);
			6'd32: w = mk(OP_EMIT, BS_BOUND, MS_LL, AC_HOLD, SRC_ZERO, J_WAIT_OUT, ST_IDLE);
			default: w = mk(OP_NOP, BS_MIX_A, MS_LL, AC_HOLD, SRC_Z, J_ALWAYS, ST_IDLE);
		endcase
		return w;
	endfunction

endpackage

/* design/xbg_rem.sv */
// xbg_rem: bit-serial restoring remainder unit, one quotient bit per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module xbg_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] rem
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [64:0] diff;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63)
				busy_q <= 1'b0;
		end
	end

	// partial remainder and dividend shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (!diff[64])
				rem_q <= diff[63:0];
			else
				rem_q <= trial[63:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

/* design/xbg_dp.sv */
// xbg_dp: datapath of the generator: state words, shared 32x32 multiplier, product
// accumulator, result register; depends on xbg_pkg and xbg_rem
`timescale 1ns / 1ps

module xbg_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  xbg_pkg::ctl_t ctl,
	input  logic [63:0]   bound_in,
	input  logic [63:0]   seed_in,
	output xbg_pkg::stat_t stat,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [63:0]   value
);

	import xbg_pkg::*;

	logic [63:0]  gen_q [4];
	logic [63:0]  acc_q;
	logic [63:0]  z_q;
	logic [63:0]  mp_q;
	logic [127:0] prod_q;
	logic [63:0]  bound_q;
	logic [1:0]   cnt_q;
	logic [63:0]  value_q;
	logic         out_valid_q;

	logic [63:0]  b_op;
	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  sm_sum;
	logic [63:0]  lo;
	logic [63:0]  g1x5;
	logic [63:0]  rot7;
	logic [63:0]  raw;
	logic [63:0]  n0;
	logic [63:0]  n1;
	logic [63:0]  n2;
	logic [63:0]  n3;
	logic [63:0]  emit_val;
	logic         out_free;
	logic         div_busy;
	logic [63:0]  lim;

	// multiplier operand selection
	always_comb begin
		case (ctl.uw.b_sel)
			BS_MIX_A: b_op = MIX_MUL_A;
			BS_MIX_B: b_op = MIX_MUL_B;
			BS_BOUND: b_op = bound_q;
			default:  b_op = bound_q;
		endcase
		case (ctl.uw.m_sel)
			MS_LL: begin
				a_half = z_q[31:0];
				b_half = b_op[31:0];
			end
			MS_LH: begin
				a_half = z_q[31:0];
				b_half = b_op[63:32];
			end
			MS_HL: begin
				a_half = z_q[63:32];
				b_half = b_op[31:0];
			end
			MS_HH: begin
				a_half = z_q[63:32];
				b_half = b_op[63:32];
			end
			default: begin
				a_half = z_q[31:0];
				b_half = b_op[31:0];
			end
		endcase
	end

	// xoshiro256** output and state update
	assign g1x5 = {gen_q[1][61:0], 2'b00} + gen_q[1];
	assign rot7 = {g1x5[56:0], g1x5[63:57]};
	assign raw  = {rot7[60:0], 3'b000} + rot7;
	always_comb begin
		n2 = gen_q[2] ^ gen_q[0];
		n3 = gen_q[3] ^ gen_q[1];
		n1 = gen_q[1] ^ n2;
		n0 = gen_q[0] ^ n3;
		n2 = n2 ^ (gen_q[1] << SHIFT_T);
		n3 = {n3[64-ROT_S3-1:0], n3[63:64-ROT_S3]};
	end

	assign sm_sum = acc_q + GOLDEN_INC;
	assign lo     = prod_q[63:0];

	// result source
	always_comb begin
		case (ctl.uw.src)
			SRC_Z:    emit_val = z_q;
			SRC_HI:   emit_val = prod_q[127:64];
			SRC_ZERO: emit_val = '0;
			default:  emit_val = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// threshold (2^64 - bound) mod bound
	xbg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.uw.op == OP_DIV_START),
		.dividend (64'd0 - bound_q),
		.divisor  (bound_q),
		.busy     (div_busy),
		.rem      (lim)
	);

	// control registers: splitmix accumulator, word counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.seed_acc)
				acc_q <= seed_in;
			else if (ctl.uw.op == OP_SM_INIT)
				acc_q <= sm_sum;
			if (ctl.uw.op == OP_WORD)
				cnt_q <= cnt_q + 2'd1;
			if (ctl.uw.op == OP_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		mp_q <= a_half * b_half;
		case (ctl.uw.acc)
			AC_LOAD:  prod_q <= {64'd0, mp_q};
			AC_ADD32: prod_q <= prod_q + {32'd0, mp_q, 32'd0};
			AC_ADD64: prod_q <= prod_q + {mp_q, 64'd0};
			default:  prod_q <= prod_q;
		endcase
		if (ctl.in_acc)
			bound_q <= bound_in;
		case (ctl.uw.op)
			OP_SM_INIT: z_q <= sm_sum ^ (sm_sum >> 30);
			OP_XS27:    z_q <= lo ^ (lo >> 27);
			OP_WORD:    gen_q[cnt_q] <= lo ^ (lo >> 31);
			OP_DRAW: begin
				z_q      <= raw;
				gen_q[0] <= n0;
				gen_q[1] <= n1;
				gen_q[2] <= n2;
				gen_q[3] <= n3;
			end
			OP_EMIT: begin
				if (out_free)
					value_q <= emit_val;
			end
			default: ;
		endcase
	end

	// status toward the sequencer
	assign stat.bound_zero = (bound_q == 64'd0);
	assign stat.lo_ge_n    = (lo >= bound_q);
	assign stat.lo_ge_lim  = (lo >= lim);
	assign stat.div_busy   = div_busy;
	assign stat.out_free   = out_free;
	assign stat.cnt_last   = (cnt_q == 2'd3);

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

/* design/xbg_seq.sv */
// xbg_seq: microcode sequencer: step counter, program table lookup, jumps and handshakes
// depends on xbg_pkg
`timescale 1ns / 1ps

module xbg_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           kind,
	output logic           in_stall,
	input  logic           seed_valid,
	output logic           seed_ready,
	input  xbg_pkg::stat_t stat,
	output xbg_pkg::ctl_t  ctl
);

	import xbg_pkg::*;

	step_t  pc_q;
	step_t  pc_d;
	step_t  pc_inc;
	uword_t uw;
	logic   idle;
	logic   seed_acc;
	logic   in_acc;

	// program fetch
	assign uw     = ucode_rom(pc_q);
	assign pc_inc = pc_q + step_t'(1);

	// handshakes, seed write wins over an input beat
	assign idle       = (uw.jmp == J_DISPATCH);
	assign seed_ready = idle;
	assign seed_acc   = idle && seed_valid;
	assign in_stall   = !idle || seed_valid;
	assign in_acc     = in_valid && !in_stall;

	// next step
	always_comb begin
		case (uw.jmp)
			J_NEXT:      pc_d = pc_inc;
			J_ALWAYS:    pc_d = uw.target;
			J_DISPATCH: begin
				if (seed_acc)
					pc_d = ST_EXPAND;
				else if (in_acc)
					pc_d = kind ? ST_BND : ST_RAW;
				else
					pc_d = pc_q;
			end
			J_CNT:       pc_d = stat.cnt_last ? ST_IDLE : uw.target;
			J_ZERO:      pc_d = stat.bound_zero ? uw.target : pc_inc;
			J_LO_GE_N:   pc_d = stat.lo_ge_n ? uw.target : pc_inc;
			J_LO_GE_LIM: pc_d = stat.lo_ge_lim ? uw.target : pc_inc;
			J_WAIT_DIV:  pc_d = stat.div_busy ? pc_q : pc_inc;
			J_WAIT_OUT:  pc_d = stat.out_free ? uw.target : pc_q;
			default:     pc_d = ST_IDLE;
		endcase
	end

	// step counter, reset starts the seed expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= ST_EXPAND;
		else
			pc_q <= pc_d;
	end

	assign ctl.uw       = uw;
	assign ctl.in_acc   = in_acc;
	assign ctl.seed_acc = seed_acc;

endmodule

/* design/xoshiro_bounded_generator_core.sv */
// xoshiro_bounded_generator_core: top level of the xoshiro256** generator with bounded draws
// depends on xbg_pkg, xbg_seq, xbg_dp, xbg_rem
//
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    kind, bound
// result    out        out_valid / out_stall  value
// seed      in         seed_valid / seed_ready seed
//
// a raw draw runs a draw step, then an emit step; one item is in work at a time
// a bounded draw computes the threshold once, by the bit-serial remainder unit, when
// the first low product is below bound, and redraws each product below it; the shared
// 32x32 multiplier builds the product of each redraw from its 32-bit halves
// after reset and after each seed write, the splitmix64 expansion fills the four state
// words before the next beat is taken; a stalled result stays in the output register while
// the next item is accepted, and the sequencer waits only when a second result is ready
`timescale 1ns / 1ps

module xoshiro_bounded_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [63:0] bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [63:0] seed
);

	import xbg_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// sequencer
	xbg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.kind       (kind),
		.in_stall   (in_stall),
		.seed_valid (seed_valid),
		.seed_ready (seed_ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	// datapath
	xbg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.bound_in  (bound),
		.seed_in   (seed),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

endmodule

/* design/xbg_checker.sv */
// xbg_checker: port-level assertions for xoshiro_bounded_generator_core, bound to the top
// depends only on the top level's ports
`timescale 1ns / 1ps

module xbg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] value,
	input logic        seed_valid,
	input logic        seed_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("stalled result changed");

	// one item at a time: the beat after an accept is stalled
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !seed_ready)
		else $error("input accepted while an item is in work");

	// a seed write starts the expansion, no beat and no write right after it
	a_seed_expand: assert property (@(posedge clk) disable iff (!arst_n)
		seed_valid && seed_ready |=> in_stall && !seed_ready)
		else $error("block idle right after seed write");

	// when idle and no seed write is offered, the input is open
	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		seed_ready && !seed_valid |-> !in_stall)
		else $error("input stalled while idle");

endmodule

bind xoshiro_bounded_generator_core xbg_checker u_chk (.*);
